@@ rtl/efd_pkg.sv @@
// Shared types and constants for the escaped API frame deframer.
package efd_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] SUM_BASE   = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BADSUM  = 2'd2,
        KIND_TRUNC   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload;
        logic [15:0] index;
        logic [15:0] length;
    } t_result;

endpackage

@@ rtl/escaped_api_frame_deframer_top.sv @@
// Top level of the escaped API frame deframer: input register, frame logic, result buffer.
//
// The slave channel takes one raw received byte per word in s_tdata[7:0]. The byte
// is held in an input register, from which the frame logic consumes it,
// removing escapes, reading the big-endian length, summing the data bytes and
// checking the checksum. A byte that yields a result pushes one word into a
// two-entry result buffer; escape bytes, length bytes and bytes taken while hunting
// for the start byte, the start byte included, yield none.
// The master channel carries the result kind in m_tuser[1:0] and, in m_tdata, the
// payload byte, the byte index and the declared frame length.
// A result word passes through the input register and then the result buffer before
// it is presented on the master side. Throughput is one byte per cycle while the
// master side keeps up; the rate is set by the frame state update.
// When the master side stalls, the buffer fills, the input register holds its byte
// and s_tready drops; it rises again in the cycle after a result word is taken, and
// nothing is lost or repeated.
// Synchronous active-low reset empties the input register and the buffer and puts
// the frame logic back to hunting for the start byte.
module escaped_api_frame_deframer_top
    import efd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] payload_byte, [23:8] byte_index, [39:24] frame_length
    output logic [1:0]  o_m_tuser    // [1:0] result_kind
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       fire;
    logic       fifo_full;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign fire       = r_in_valid && !fifo_full;
    assign o_s_tready = !r_in_valid || fire;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    efd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    efd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_res)
    );

    assign o_m_tdata = {out_res.length, out_res.index, out_res.payload};
    assign o_m_tuser = out_res.kind;

endmodule

@@ rtl/efd_core.sv @@
// Frame state machine that turns one received byte into at most one result word.
module efd_core
    import efd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic [7:0] i_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;

    logic        is_start;
    logic        is_esc;
    logic        in_frame;
    logic [7:0]  b_val;
    logic [15:0] seen_inc;

    assign is_start = (i_byte == START_BYTE);
    assign is_esc   = !r_esc && (i_byte == ESC_BYTE);
    assign in_frame = (r_phase == PH_LEN_HI) || (r_phase == PH_LEN_LO) ||
                      (r_phase == PH_DATA) || (r_phase == PH_CSUM);
    assign b_val    = r_esc ? (i_byte ^ ESC_XOR) : i_byte;
    assign seen_inc = r_seen + 16'd1;

    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            if (!in_frame) begin
                n_phase = is_start ? PH_LEN_HI : PH_HUNT;
            end else if (is_start) begin
                n_phase = PH_LEN_HI;
            end else if (!is_esc) begin
                case (r_phase)
                    PH_LEN_HI: n_phase = PH_LEN_LO;
                    PH_LEN_LO: n_phase = ({r_len[15:8], b_val} == 16'd0) ? PH_CSUM : PH_DATA;
                    PH_DATA:   n_phase = (seen_inc == r_len) ? PH_CSUM : PH_DATA;
                    default:   n_phase = PH_HUNT;
                endcase
            end
        end
    end

    always_comb begin
        n_esc          = r_esc;
        n_len          = r_len;
        n_seen         = r_seen;
        n_sum          = r_sum;
        o_res_valid    = 1'b0;
        o_res.kind     = KIND_PAYLOAD;
        o_res.payload  = 8'd0;
        o_res.index    = r_seen;
        o_res.length   = r_len;
        if (i_fire) begin
            if (!in_frame || is_start) begin
                if (is_start) begin
                    n_esc  = 1'b0;
                    n_len  = 16'd0;
                    n_seen = 16'd0;
                    n_sum  = 8'd0;
                end
                if (in_frame) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_TRUNC;
                end
            end else if (is_esc) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                case (r_phase)
                    PH_LEN_HI: n_len = {b_val, 8'd0};
                    PH_LEN_LO: n_len = {r_len[15:8], b_val};
                    PH_DATA: begin
                        o_res_valid   = 1'b1;
                        o_res.kind    = KIND_PAYLOAD;
                        o_res.payload = b_val;
                        n_sum         = r_sum + b_val;
                        n_seen        = seen_inc;
                    end
                    default: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = ((SUM_BASE - r_sum) == b_val) ? KIND_GOOD : KIND_BADSUM;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
            r_len   <= 16'd0;
            r_seen  <= 16'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_fire)
        else $error("Result produced without an accepted byte.");

    a_payload_from_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PAYLOAD) |-> (r_phase == PH_DATA))
        else $error("Payload word outside the data phase.");

    a_status_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind != KIND_PAYLOAD) |-> (o_res.payload == 8'd0))
        else $error("Status word carries a nonzero payload.");

    a_start_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && is_start) |=> (r_phase == PH_LEN_HI && r_seen == 16'd0 && r_sum == 8'd0))
        else $error("Start byte did not open a fresh frame.");

endmodule

@@ rtl/efd_out_fifo.sv @@
// Two-entry result buffer that decouples the frame logic from the output stall.
module efd_out_fifo
    import efd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the escaped API frame deframer, with random stream stalls.
`timescale 1ns / 100ps

module tb;
    import efd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;           // [7:0] payload_byte, [23:8] byte_index, [39:24] frame_length
    logic [1:0]  o_m_tuser;           // [1:0] result_kind

    escaped_api_frame_deframer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    logic [7:0] rx_q [$];
    t_result    pending_results [$];

    t_phase      fr_phase = PH_HUNT;
    logic        fr_esc = 1'b0;
    logic [15:0] fr_len = '0;
    logic [15:0] fr_count = '0;
    logic [7:0]  fr_sum = '0;

    int n_total = 0;
    int n_sent = 0;
    int n_bad = 0;
    bit s_fired = 1'b0;
    bit m_fired = 1'b0;
    bit hold_off = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_rx_byte(input logic [7:0] b);
        rx_q = {rx_q, b};
    endfunction

    function automatic void start_frame();
        fr_phase = PH_LEN_HI;
        fr_esc   = 1'b0;
        fr_len   = '0;
        fr_count = '0;
        fr_sum   = '0;
    endfunction

    function automatic void post_result(input t_kind kind, input logic [7:0] payload);
        t_result r;
        r.kind    = kind;
        r.payload = payload;
        r.index   = fr_count;
        r.length  = fr_len;
        pending_results = {pending_results, r};
    endfunction

    function automatic void deframe_byte(input logic [7:0] raw);
        logic [7:0] b;
        if (fr_phase == PH_HUNT || fr_phase > PH_CSUM) begin
            fr_phase = PH_HUNT;
            if (raw == START_BYTE)
                start_frame();
            return;
        end
        if (raw == START_BYTE) begin
            post_result(KIND_TRUNC, 8'h00);
            start_frame();
            return;
        end
        if (!fr_esc && raw == ESC_BYTE) begin
            fr_esc = 1'b1;
            return;
        end
        b = fr_esc ? (raw ^ ESC_XOR) : raw;
        fr_esc = 1'b0;
        case (fr_phase)
            PH_LEN_HI: begin
                fr_len   = {b, 8'h00};
                fr_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                fr_len   = {fr_len[15:8], b};
                fr_phase = (fr_len == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                post_result(KIND_PAYLOAD, b);
                fr_sum   = fr_sum + b;
                fr_count = fr_count + 16'd1;
                if (fr_count == fr_len)
                    fr_phase = PH_CSUM;
            end
            default: begin
                post_result((SUM_BASE - fr_sum == b) ? KIND_GOOD : KIND_BADSUM, 8'h00);
                fr_phase = PH_HUNT;
            end
        endcase
    endfunction

    function automatic void push_coded(input logic [7:0] b);
        if (b == START_BYTE || b == ESC_BYTE
                || ((b ^ ESC_XOR) != START_BYTE && $urandom_range(0, 19) == 0)) begin
            add_rx_byte(ESC_BYTE);
            add_rx_byte(b ^ ESC_XOR);
        end else begin
            add_rx_byte(b);
        end
    endfunction

    function automatic logic [7:0] pick_data();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0: b = START_BYTE;
            1: b = ESC_BYTE;
            2: b = START_BYTE ^ ESC_XOR;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // A frame may be cut short at a random point, sometimes right after an escape.
    function automatic void add_frame();
        int n;
        int cut;
        logic [15:0] len;
        logic [7:0] s;
        logic [7:0] b;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n + 2) : -1;
        len = 16'(n);
        s = '0;
        add_rx_byte(START_BYTE);
        for (int i = 0; i < n + 3; i++) begin
            if (i == cut) begin
                if ($urandom_range(0, 1) == 0)
                    add_rx_byte(ESC_BYTE);
                return;
            end
            if (i == 0) begin
                b = len[15:8];
            end else if (i == 1) begin
                b = len[7:0];
            end else if (i < n + 2) begin
                b = pick_data();
                s = s + b;
            end else begin
                b = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : SUM_BASE - s;
            end
            push_coded(b);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        s_fired = i_rst_n && i_s_tvalid && o_s_tready;
        m_fired = i_rst_n && o_m_tvalid && i_m_tready;
        if (s_fired)
            deframe_byte(i_s_tdata);
        if (m_fired) begin
            got = {o_m_tuser, o_m_tdata[7:0], o_m_tdata[23:8], o_m_tdata[39:24]};
            if (pending_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected word: kind %0d payload %h index %0d length %0d",
                             got.kind, got.payload, got.index, got.length);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.kind !== want.kind || got.payload !== want.payload
                        || got.index !== want.index || got.length !== want.length) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected kind %0d payload %h index %0d length %0d,",
                                 want.kind, want.payload, want.index, want.length,
                                 " got kind %0d payload %h index %0d length %0d",
                                 got.kind, got.payload, got.index, got.length);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic       v;
        logic [7:0] d;
        if (i_rst_n) begin
            v = i_s_tvalid;
            d = i_s_tdata;
            if (s_fired) begin
                v = 1'b0;
                n_sent++;
            end
            if (!v) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (rx_q.size() > 0) begin
                    d = rx_q[0];
                    rx_q.delete(0);
                    v = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        tx_quiet = !tx_quiet;
                    tx_gap = tx_quiet ? 0 : $urandom_range(0, 9);
                end
            end
            i_s_tvalid <= v;
            i_s_tdata  <= d;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (m_fired) begin
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= !hold_off;
            end
        end
    end

    // The receiver stops for a long stretch so that the result buffer fills and input stalls.
    initial begin
        wait (n_sent >= 200);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        rx_q = '{ESC_BYTE, 8'hFF,
                 START_BYTE, 8'h00, 8'h02, ESC_BYTE, 8'h5E, 8'hFF, 8'h82,
                 START_BYTE, 8'h00, 8'h00, 8'hFF,
                 START_BYTE, 8'h00, 8'h00, 8'h00,
                 START_BYTE, START_BYTE, 8'h12, START_BYTE, 8'hFF, 8'hFF,
                 ESC_BYTE, 8'h5D, ESC_BYTE, START_BYTE};
        while (rx_q.size() < 750) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_rx_byte(8'($urandom_range(0, 255)));
            end
            add_frame();
        end
        n_total = rx_q.size();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == n_total);
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && pending_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
